/* rtl/thresholded_window_level_to_db_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the window level meter
// Shared property wrappers, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef THRESHOLDED_WINDOW_LEVEL_TO_DB_MACROS_SVH
`define THRESHOLDED_WINDOW_LEVEL_TO_DB_MACROS_SVH

// same-cycle implication
`define TWL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TWL_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/twl_pkg.sv */
// ----------------------------------------------------------------------------
// twl_pkg
// Register map, reset values and dB map coefficients of the level meter.
// ----------------------------------------------------------------------------
package twl_pkg;

    localparam int CFG_W  = 12;
    localparam int WLEN_W = 13;
    localparam int LEVEL_W = 12;
    localparam int DB_W   = 8;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [CFG_W-1:0]  RST_THRESHOLD  = 12'd1887;
    localparam logic [WLEN_W-1:0] RST_WINDOW_LEN = 13'd2000;
    localparam logic [CFG_W-1:0]  RST_OFFSET     = 12'd0;
    localparam logic [CFG_W-1:0]  RST_BREAKPOINT = 12'd1965;

    // Q16 coefficients of the two-segment map
    localparam logic [15:0] STEEP_GAIN   = 16'd46365;
    localparam logic [15:0] SHALLOW_GAIN = 16'd933;
    localparam logic [26:0] STEEP_BIAS   = 27'd86500966;
    localparam logic [26:0] SHALLOW_BIAS = 27'd3201434;
    localparam int BIAS_W = 27;

    typedef enum logic [1:0] {
        REG_THRESHOLD     = 2'd0,
        REG_WINDOW_LENGTH = 2'd1,
        REG_LEVEL_OFFSET  = 2'd2,
        REG_BREAKPOINT    = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [CFG_W-1:0]  threshold;
        logic [WLEN_W-1:0] window_length;
        logic [CFG_W-1:0]  level_offset;
        logic [CFG_W-1:0]  breakpoint;
    } t_cfg;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

/* rtl/twl_sample_if.sv */
// ----------------------------------------------------------------------------
// twl_sample_if
// Valid/ready channel carrying one converter sample per transaction.
// ----------------------------------------------------------------------------
interface twl_sample_if #(
    parameter int SAMPLE_BITS = 12
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

/* rtl/twl_level_if.sv */
// ----------------------------------------------------------------------------
// twl_level_if
// Valid/ready channel carrying one window result per transaction.
// ----------------------------------------------------------------------------
interface twl_level_if;
    logic        valid;
    logic        ready;
    logic [11:0] adc_level;
    logic [7:0]  level_db;
    logic        empty_window;

    modport source (output valid, output adc_level, output level_db,
                    output empty_window, input ready);
    modport sink   (input valid, input adc_level, input level_db,
                    input empty_window, output ready);
endinterface

/* rtl/twl_regs.sv */
// ----------------------------------------------------------------------------
// twl_regs
// APB configuration registers: threshold, window length, offset, breakpoint.
// ----------------------------------------------------------------------------
module twl_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [twl_pkg::PADDR_W-1:0]   paddr,
    input  logic [twl_pkg::PDATA_W-1:0]   pwdata,
    output logic [twl_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output twl_pkg::t_cfg                 o_cfg
);
    import twl_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold     <= RST_THRESHOLD;
            r_cfg.window_length <= RST_WINDOW_LEN;
            r_cfg.level_offset  <= RST_OFFSET;
            r_cfg.breakpoint    <= RST_BREAKPOINT;
        end else if (wr_en) begin
            case (reg_idx)
                REG_THRESHOLD:     r_cfg.threshold     <= pwdata[CFG_W-1:0];
                REG_WINDOW_LENGTH: r_cfg.window_length <= pwdata[WLEN_W-1:0];
                REG_LEVEL_OFFSET:  r_cfg.level_offset  <= pwdata[CFG_W-1:0];
                REG_BREAKPOINT:    r_cfg.breakpoint    <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_THRESHOLD:     prdata = PDATA_W'(r_cfg.threshold);
            REG_WINDOW_LENGTH: prdata = PDATA_W'(r_cfg.window_length);
            REG_LEVEL_OFFSET:  prdata = PDATA_W'(r_cfg.level_offset);
            REG_BREAKPOINT:    prdata = PDATA_W'(r_cfg.breakpoint);
            default:           prdata = '0;
        endcase
    end

endmodule

/* rtl/twl_div.sv */
// ----------------------------------------------------------------------------
// twl_div
// Restoring divider, one quotient bit per cycle. The caller guarantees the
// quotient fits in Q_W bits, i.e. the upper dividend bits are below divisor.
// ----------------------------------------------------------------------------
module twl_div #(
    parameter int DVD_W = 24,
    parameter int DIV_W = 13,
    parameter int Q_W   = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DVD_W-1:0]   i_dividend,
    input  logic [DIV_W-1:0]   i_divisor,
    output logic [Q_W-1:0]     o_quotient,
    output twl_pkg::t_div_stat o_stat
);
    import twl_pkg::*;

    localparam int STEP_W = $clog2(Q_W + 1);

    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_div;
    logic [Q_W-1:0]    r_lo;
    logic [Q_W-1:0]    r_quo;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;
    logic [DIV_W:0]    trial;
    logic [DIV_W:0]    diff;
    logic              fits;

    assign trial = {r_rem, r_lo[Q_W-1]};
    assign fits  = trial >= {1'b0, r_div};
    assign diff  = trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(Q_W);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[DVD_W-1:Q_W];
            r_lo  <= i_dividend[Q_W-1:0];
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            r_lo  <= {r_lo[Q_W-2:0], 1'b0};
            r_quo <= {r_quo[Q_W-2:0], fits};
        end
    end

    assign o_quotient  = r_quo;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

/* rtl/thresholded_window_level_to_db.sv */
// ----------------------------------------------------------------------------
// thresholded_window_level_to_db
// Window level meter: thresholded mean of samples, mapped to decibels.
// ----------------------------------------------------------------------------
// Usage:
//   Samples arrive on i_sample_if (valid/ready). Samples strictly above the
//   threshold register are summed and counted over window_length samples.
//   A sample that does not close a window is taken and the input stays ready.
//   The sample closing a window starts the result computation; the input is
//   not ready until the result is placed in the output register.
//   A non-empty window result goes through the divider, which yields one
//   quotient bit per cycle, then the offset, multiply and map steps. An
//   empty window result skips the divider and those steps. The input is
//   ready again as the result loads.
//   Results leave on o_level_if (valid/ready) from an output register; while
//   the receiver stalls the input keeps taking samples until the next window
//   result is ready, which then waits for the register to drain.
//   Configuration is written through the APB port, pready always high.
//   Synchronous reset clears the window and restores register defaults.
// ----------------------------------------------------------------------------
module thresholded_window_level_to_db #(
    parameter int MAX_WINDOW  = 4096,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    twl_sample_if.sink                  i_sample_if,
    twl_level_if.source                 o_level_if,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [twl_pkg::PADDR_W-1:0] paddr,
    input  logic [twl_pkg::PDATA_W-1:0] pwdata,
    output logic [twl_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import twl_pkg::*;

    localparam int SB   = SAMPLE_BITS;
    localparam int IW   = $clog2(MAX_WINDOW + 1);
    localparam int SW   = SB + IW;
    localparam int CW   = (SB > CFG_W) ? SB : CFG_W;
    localparam int PW   = 16 + SB;
    localparam int YW   = ((PW > BIAS_W) ? PW : BIAS_W) + 2;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DIV  = 6'b000010,
        S_OFFS = 6'b000100,
        S_MUL  = 6'b001000,
        S_MAP  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_cfg      cfg;
    t_div_stat div_stat;
    t_state    r_state, n_state;

    logic [SW-1:0]  r_sum, n_sum;
    logic [IW-1:0]  r_cnt, n_cnt;
    logic [IW-1:0]  r_idx, n_idx;
    logic [SB-1:0]  r_mean;
    logic [SB-1:0]  r_v;
    logic           r_steep;
    logic [PW-1:0]  r_prod;
    logic [LEVEL_W-1:0] r_res_level;
    logic [DB_W-1:0]    r_res_db;
    logic               r_res_empty;
    logic               r_out_valid;
    logic [LEVEL_W-1:0] r_out_level;
    logic [DB_W-1:0]    r_out_db;
    logic               r_out_empty;

    logic [SB-1:0]  sample;
    logic           in_fire;
    logic           hit;
    logic [31:0]    eff_len;
    logic           close;
    logic           div_start;
    logic [SB-1:0]  quotient;
    logic [CW-1:0]  mean_x, offs_x;
    logic [SB-1:0]  v_next;
    logic [YW-1:0]  y;
    logic [DB_W-1:0] db_next;
    logic           out_free;

    twl_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    twl_div #(
        .DVD_W (SW),
        .DIV_W (IW),
        .Q_W   (SB)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (n_sum),
        .i_divisor  (n_cnt),
        .o_quotient (quotient),
        .o_stat     (div_stat)
    );

    assign sample            = i_sample_if.sample;
    assign i_sample_if.ready = (r_state == S_IDLE);
    assign in_fire           = i_sample_if.valid && i_sample_if.ready;
    assign hit               = CW'(sample) > CW'(cfg.threshold);
    assign out_free          = !r_out_valid || o_level_if.ready;

    always_comb begin
        if (cfg.window_length == '0) begin
            eff_len = 32'd1;
        end else if (32'(cfg.window_length) > 32'(MAX_WINDOW)) begin
            eff_len = 32'(MAX_WINDOW);
        end else begin
            eff_len = 32'(cfg.window_length);
        end
    end

    assign n_sum     = hit ? (r_sum + SW'(sample)) : r_sum;
    assign n_cnt     = hit ? (r_cnt + 1'b1) : r_cnt;
    assign n_idx     = r_idx + 1'b1;
    assign close     = 32'(n_idx) >= eff_len;
    assign div_start = in_fire && close && (n_cnt != '0);

    // offset subtraction, saturating at zero
    assign mean_x = CW'(r_mean);
    assign offs_x = CW'(cfg.level_offset);
    assign v_next = (mean_x > offs_x) ? SB'(mean_x - offs_x) : '0;

    always_comb begin
        if (r_steep) begin
            y = YW'(r_prod) - YW'(STEEP_BIAS);
        end else begin
            y = YW'(r_prod) + YW'(SHALLOW_BIAS);
        end
        if (y[YW-1] || (y == '0)) begin
            db_next = '0;
        end else if (y[YW-1:24] != '0) begin
            db_next = '1;
        end else begin
            db_next = y[23:16];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire && close) begin
                    n_state = (n_cnt == '0) ? S_OUT : S_DIV;
                end
            end
            S_DIV:   if (div_stat.done) n_state = S_OFFS;
            S_OFFS:  n_state = S_MUL;
            S_MUL:   n_state = S_MAP;
            S_MAP:   n_state = S_OUT;
            S_OUT:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_fire) begin
                if (close) begin
                    r_sum <= '0;
                    r_cnt <= '0;
                    r_idx <= '0;
                end else begin
                    r_sum <= n_sum;
                    r_cnt <= n_cnt;
                    r_idx <= n_idx;
                end
            end
            if ((r_state == S_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_level_if.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && in_fire && close && (n_cnt == '0)) begin
            r_res_level <= '0;
            r_res_db    <= '0;
            r_res_empty <= 1'b1;
        end
        if ((r_state == S_DIV) && div_stat.done) begin
            r_mean <= quotient;
        end
        if (r_state == S_OFFS) begin
            r_v     <= v_next;
            r_steep <= CW'(v_next) < CW'(cfg.breakpoint);
        end
        if (r_state == S_MUL) begin
            r_prod <= (r_steep ? PW'(STEEP_GAIN) : PW'(SHALLOW_GAIN)) * PW'(r_v);
        end
        if (r_state == S_MAP) begin
            r_res_level <= LEVEL_W'(r_mean);
            r_res_db    <= db_next;
            r_res_empty <= 1'b0;
        end
        if ((r_state == S_OUT) && out_free) begin
            r_out_level <= r_res_level;
            r_out_db    <= r_res_db;
            r_out_empty <= r_res_empty;
        end
    end

    assign o_level_if.valid        = r_out_valid;
    assign o_level_if.adc_level    = r_out_level;
    assign o_level_if.level_db     = r_out_db;
    assign o_level_if.empty_window = r_out_empty;

endmodule

/* rtl/twl_checker.sv */
// ----------------------------------------------------------------------------
// twl_checker
// Port-level assertions on the level meter, bound to the top level.
// ----------------------------------------------------------------------------
`include "thresholded_window_level_to_db_macros.svh"

module twl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [11:0] i_adc_level,
    input logic [7:0]  i_level_db,
    input logic        i_empty_window
);

    `TWL_ASSERT_IMP(a_empty_zero, i_out_valid && i_empty_window,
        (i_adc_level == 12'd0) && (i_level_db == 8'd0), "empty window with nonzero level")

    `TWL_ASSERT_IMP(a_load_busy, $rose(i_out_valid), !$past(i_in_ready),
        "result loaded while input was ready")

    `TWL_ASSERT_NXT(a_out_hold, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_adc_level) && $stable(i_level_db) && $stable(i_empty_window),
        "stalled result changed")

endmodule

bind thresholded_window_level_to_db twl_checker u_twl_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_sample_if.ready),
    .i_out_valid    (o_level_if.valid),
    .i_out_ready    (o_level_if.ready),
    .i_adc_level    (o_level_if.adc_level),
    .i_level_db     (o_level_if.level_db),
    .i_empty_window (o_level_if.empty_window)
);
